@@ hdl/c2bs_pkg.sv @@
// c2bs_pkg: shared constants, types and tables for the cartesian to bicycle state core
// no dependencies
`default_nettype none
package c2bs_pkg;

  localparam int CordicStages = 16;
  localparam int TabLen = 24;
  localparam int NStages = (CordicStages < TabLen) ? CordicStages : TabLen;
  localparam int SqrtSteps = 17;
  localparam int DivSteps = 17;

  localparam logic signed [19:0] AngPi = 20'sd205887;
  localparam logic signed [19:0] AngPiHalf = 20'sd102944;
  localparam logic signed [32:0] CordicX0 = 33'sd652032874;

  function automatic logic signed [19:0] atan_val(input int i);
    logic signed [19:0] r;
    case (i)
      0: r = 20'sd51472;
      1: r = 20'sd30385;
      2: r = 20'sd16055;
      3: r = 20'sd8150;
      4: r = 20'sd4091;
      5: r = 20'sd2047;
      6: r = 20'sd1024;
      7: r = 20'sd512;
      8: r = 20'sd256;
      9: r = 20'sd128;
      10: r = 20'sd64;
      11: r = 20'sd32;
      12: r = 20'sd16;
      13: r = 20'sd8;
      14: r = 20'sd4;
      15: r = 20'sd2;
      16: r = 20'sd1;
      default: r = 20'sd0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic        [31:0] stamp;
  } pass_t;

endpackage
`default_nettype wire

@@ hdl/c2bs_cordic.sv @@
// c2bs_cordic: pipelined rotation cordic, one stage per used atan table entry
// depends on c2bs_pkg
`default_nettype none
module c2bs_cordic (
  input  wire                      clk,
  input  wire                      en,
  input  wire signed [15:0]        heading,
  output logic signed [32:0]       cos_o,
  output logic signed [32:0]       sin_o
);
  import c2bs_pkg::*;

  logic signed [32:0] x_r [NStages+1];
  logic signed [32:0] y_r [NStages+1];
  logic signed [19:0] z_r [NStages+1];
  logic               neg_r [NStages+1];
  logic signed [19:0] ang;

  assign ang = 20'(heading) <<< 3;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CordicX0;
      y_r[0] <= '0;
      neg_r[0] <= (ang > AngPiHalf) || (ang < -AngPiHalf);
      if (ang > AngPiHalf) z_r[0] <= ang - AngPi;
      else if (ang < -AngPiHalf) z_r[0] <= ang + AngPi;
      else z_r[0] <= ang;
    end
  end

  for (genvar i = 0; i < NStages; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_val(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_val(i);
        end
      end
    end
  end

  assign cos_o = neg_r[NStages] ? -x_r[NStages] : x_r[NStages];
  assign sin_o = neg_r[NStages] ? -y_r[NStages] : y_r[NStages];
endmodule
`default_nettype wire

@@ hdl/c2bs_sqrt.sv @@
// c2bs_sqrt: pipelined rounded integer square root, one result bit per stage
// depends on c2bs_pkg
`default_nettype none
module c2bs_sqrt (
  input  wire         clk,
  input  wire         en,
  input  wire  [31:0] sumsq,
  output logic [16:0] root,
  output logic [31:0] sumsq_o
);
  import c2bs_pkg::*;

  logic [31:0] rem_r [SqrtSteps];
  logic [15:0] q_r   [SqrtSteps];
  logic [31:0] s_r   [SqrtSteps];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      q_r[0] <= '0;
      s_r[0] <= sumsq;
    end
  end

  // restoring root; q holds the partial root, rem the remainder of the leading bits
  for (genvar i = 0; i < SqrtSteps - 1; i++) begin : g_step
    logic [33:0] part;
    logic [33:0] trial;
    assign part = {rem_r[i], s_r[i][31-2*i -: 2]};
    assign trial = {16'b0, q_r[i], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        if (part >= trial) begin
          rem_r[i+1] <= 32'(part - trial);
          q_r[i+1] <= {q_r[i][14:0], 1'b1};
        end else begin
          rem_r[i+1] <= part[31:0];
          q_r[i+1] <= {q_r[i][14:0], 1'b0};
        end
        s_r[i+1] <= s_r[i];
      end
    end
  end

  // round to nearest: a remainder above the floor root adds one
  assign root = (rem_r[SqrtSteps-1] > 32'(q_r[SqrtSteps-1])) ?
                17'(q_r[SqrtSteps-1]) + 17'd1 : 17'(q_r[SqrtSteps-1]);
  assign sumsq_o = s_r[SqrtSteps-1];
endmodule
`default_nettype wire

@@ hdl/cartesian_to_bicycle_state_core.sv @@
// cartesian_to_bicycle_state_core: top level of the converter
// depends on c2bs_pkg, c2bs_cordic, c2bs_sqrt
//
// channel   dir  handshake       word
// in_       in   valid / stall   pos, heading, vel, acc, stamp
// out_      out  valid / stall   pos, heading, speed, long_accel, curvature, stamp, saturated
// cfg_      in   valid / ready   min_speed
//
// one word per cycle unless out_ stalls; stages: cordic, multiply and sum, root,
// round and saturate, divide
// a stall on out_ while out_valid is high holds the whole pipeline and is passed back as in_stall
// reset clears valid bits and sets min_speed to 1
`default_nettype none
module cartesian_to_bicycle_state_core (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire signed [31:0]  in_pos_x,
  input  wire signed [31:0]  in_pos_y,
  input  wire signed [15:0]  in_heading,
  input  wire signed [15:0]  in_vel_x,
  input  wire signed [15:0]  in_vel_y,
  input  wire signed [15:0]  in_acc_x,
  input  wire signed [15:0]  in_acc_y,
  input  wire        [31:0]  in_stamp,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [15:0] out_heading,
  output logic        [15:0] out_speed,
  output logic signed [15:0] out_long_accel,
  output logic signed [15:0] out_curvature,
  output logic        [31:0] out_stamp,
  output logic               out_saturated,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire        [15:0]  cfg_min_speed
);
  import c2bs_pkg::*;

  localparam int CLat = NStages + 1;
  localparam int Lat = CLat + 4 + SqrtSteps + DivSteps;

  logic en;
  logic [15:0] min_speed_r;
  logic v_r [Lat];

  assign en = !out_stall || !out_valid;
  assign in_stall = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) min_speed_r <= 16'd1;
    else if (cfg_valid) min_speed_r <= cfg_min_speed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Lat; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < Lat; i++) v_r[i] <= v_r[i-1];
    end
  end
  assign out_valid = v_r[Lat-1];

  // operands delayed alongside the cordic
  pass_t pass_r [CLat];
  logic signed [15:0] ax_r [CLat], ay_r [CLat];
  logic [31:0] ss_r [CLat];
  logic signed [32:0] c_w, s_w;

  always_ff @(posedge clk) begin
    if (en) begin
      pass_r[0] <= '{in_pos_x, in_pos_y, in_heading, in_stamp};
      ax_r[0] <= in_acc_x;
      ay_r[0] <= in_acc_y;
      ss_r[0] <= 32'(in_vel_x * in_vel_x) + 32'(in_vel_y * in_vel_y);
      for (int i = 1; i < CLat; i++) begin
        pass_r[i] <= pass_r[i-1];
        ax_r[i] <= ax_r[i-1];
        ay_r[i] <= ay_r[i-1];
        ss_r[i] <= ss_r[i-1];
      end
    end
  end

  c2bs_cordic u_cordic (.clk(clk), .en(en), .heading(in_heading), .cos_o(c_w), .sin_o(s_w));

  // products
  logic signed [49:0] p_xc_r, p_ys_r, p_yc_r, p_xs_r;
  logic signed [50:0] lon_r, an_r;
  pass_t pa_r, pb_r;
  logic [31:0] ssa_r, ssb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_xc_r <= 50'(ax_r[CLat-1]) * 50'(c_w);
      p_ys_r <= 50'(ay_r[CLat-1]) * 50'(s_w);
      p_yc_r <= 50'(ay_r[CLat-1]) * 50'(c_w);
      p_xs_r <= 50'(ax_r[CLat-1]) * 50'(s_w);
      pa_r <= pass_r[CLat-1];
      ssa_r <= ss_r[CLat-1];
      lon_r <= 51'(p_xc_r) + 51'(p_ys_r) + (51'sd1 <<< 29);
      an_r <= 51'(p_yc_r) - 51'(p_xs_r);
      pb_r <= pa_r;
      ssb_r <= ssa_r;
    end
  end

  // rounded square root pipeline starting from ssb_r
  logic [16:0] spd_w;
  logic [31:0] ss_w;
  c2bs_sqrt u_sqrt (.clk(clk), .en(en), .sumsq(ssb_r), .root(spd_w), .sumsq_o(ss_w));

  // delay lon/an/pass through the root
  logic signed [50:0] lon_d [SqrtSteps], an_d [SqrtSteps];
  pass_t pd [SqrtSteps];
  always_ff @(posedge clk) begin
    if (en) begin
      lon_d[0] <= lon_r; an_d[0] <= an_r; pd[0] <= pb_r;
      for (int i = 1; i < SqrtSteps; i++) begin
        lon_d[i] <= lon_d[i-1]; an_d[i] <= an_d[i-1]; pd[i] <= pd[i-1];
      end
    end
  end

  // final stage: saturation; curvature by restoring divide across stages
  // quotient needs 17 bits; d = S<<10, q = (|an| + d/2)/d
  logic [15:0] speed_r;
  logic [15:0] lon_sat_r;
  logic        lclip_r, slow_r, neg_r;
  logic [50:0] num_r;
  logic [41:0] den_r;
  pass_t pe_r;
  always_ff @(posedge clk) begin
    logic signed [50:0] l;
    logic [50:0] mag;
    if (en) begin
      l = lon_d[SqrtSteps-1] >>> 30;
      mag = an_d[SqrtSteps-1][50] ? 51'(-an_d[SqrtSteps-1]) : 51'(an_d[SqrtSteps-1]);
      speed_r <= spd_w[15:0];
      lclip_r <= (l > 51'sd32767) || (l < -51'sd32768);
      lon_sat_r <= (l > 51'sd32767) ? 16'h7fff : (l < -51'sd32768) ? 16'h8000 : l[15:0];
      slow_r <= !(spd_w > 17'(min_speed_r)) || (ss_w == 0);
      neg_r <= an_d[SqrtSteps-1][50];
      den_r <= {ss_w, 10'b0};
      num_r <= mag + 51'({ss_w, 9'b0});
      pe_r <= pd[SqrtSteps-1];
    end
  end

  // divider pipeline, one quotient bit per stage, msb first
  logic [50:0] dr_r [DivSteps+1];
  logic [16:0] dq_r [DivSteps+1];
  logic [41:0] dd_r [DivSteps+1];
  logic        ds_r [DivSteps+1], dn_r [DivSteps+1], dc_r [DivSteps+1];
  logic [15:0] dsp_r [DivSteps+1], dl_r [DivSteps+1];
  pass_t       dp_r [DivSteps+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dr_r[0] <= num_r; dq_r[0] <= '0; dd_r[0] <= den_r;
      ds_r[0] <= slow_r; dn_r[0] <= neg_r; dc_r[0] <= lclip_r;
      dsp_r[0] <= speed_r; dl_r[0] <= lon_sat_r; dp_r[0] <= pe_r;
      for (int i = 0; i < DivSteps; i++) begin
        logic [67:0] sh;
        sh = 68'(dd_r[i]) << (16 - i);
        if (68'(dr_r[i]) >= sh && dq_r[i] != 17'h1ffff) begin
          dr_r[i+1] <= 51'(68'(dr_r[i]) - sh);
          dq_r[i+1] <= dq_r[i] | (17'd1 << (16 - i));
        end else begin
          dr_r[i+1] <= dr_r[i];
          dq_r[i+1] <= dq_r[i];
        end
        dd_r[i+1] <= dd_r[i]; ds_r[i+1] <= ds_r[i]; dn_r[i+1] <= dn_r[i];
        dc_r[i+1] <= dc_r[i]; dsp_r[i+1] <= dsp_r[i]; dl_r[i+1] <= dl_r[i];
        dp_r[i+1] <= dp_r[i];
      end
    end
  end

  // quotient above the 17-bit range means it saturates anyway
  logic [17:0] qbig;
  logic [16:0] qv;
  logic        cclip;
  logic [15:0] curv;
  always_comb begin
    qbig = (dr_r[DivSteps] >= 51'(dd_r[DivSteps]) && dq_r[DivSteps] == 17'h1ffff) ?
           18'h3ffff : 18'(dq_r[DivSteps]);
    qv = (qbig > 18'd65536) ? 17'd65536 : qbig[16:0];
    if (ds_r[DivSteps]) begin
      curv = '0; cclip = 1'b0;
    end else if (dn_r[DivSteps]) begin
      cclip = 1'b0;
      curv = 16'(-qv);
      if (qv > 17'd32768) begin curv = 16'h8000; cclip = 1'b1; end
    end else begin
      cclip = qv > 17'd32767;
      curv = cclip ? 16'h7fff : qv[15:0];
    end
  end

  // last register, shifted with the valid chain
  assign out_pos_x = dp_r[DivSteps].pos_x;
  assign out_pos_y = dp_r[DivSteps].pos_y;
  assign out_heading = dp_r[DivSteps].heading;
  assign out_stamp = dp_r[DivSteps].stamp;
  assign out_speed = dsp_r[DivSteps];
  assign out_long_accel = dl_r[DivSteps];
  assign out_curvature = curv;
  assign out_saturated = dc_r[DivSteps] | cclip;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_stamp)) else $error("word lost");
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall)) else $error("stall mismatch");
  a_slow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ds_r[DivSteps] |-> out_curvature == 16'd0) else $error("slow curvature");
endmodule
`default_nettype wire
